// File: hw/rtl/adr_pkg.sv
package adr_pkg;

    // Field widths
    localparam int CHAN_W    = 3;
    localparam int SMP_W     = 12;
    localparam int VAL_W     = 12;
    localparam int CFG_W     = 24;
    localparam int PANEL_W   = 3;
    localparam int BYTE_W    = 8;
    localparam int REG_IDX_W = 2;

    // Decimal conversion
    localparam int DIGITS    = 4;
    localparam int DIGIT_W   = 4;
    localparam int DIG_IDX_W = 2;
    localparam int ND_W      = 3;
    localparam int POS_W     = 3;
    localparam int RECIP_W   = 13;
    localparam int RECIP_SHIFT = 15;
    localparam logic [RECIP_W-1:0] RECIP_10 = 13'd3277;

    // Defaults for top-level parameters
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH      = 2;

    // Register reset values
    localparam logic [VAL_W-1:0] DEADBAND_RST   = 12'd2;
    localparam logic [VAL_W-1:0] FULL_SCALE_RST = 12'd4095;
    localparam logic [CFG_W-1:0] PANEL_MAP_RST  = 24'd8666581;

    // ASCII codes
    localparam logic [BYTE_W-1:0] ASC_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASC_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] ASC_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] ASC_SEMI  = 8'h3B;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEADBAND   = 2'd0,
        REG_FULL_SCALE = 2'd1,
        REG_PANEL_MAP  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [VAL_W-1:0] deadband;
        logic [VAL_W-1:0] full_scale;
        logic [CFG_W-1:0] panel_map;
    } cfg_t;

    typedef struct packed {
        logic [PANEL_W-1:0] panel;
        logic [VAL_W-1:0]   report;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        CV_IDLE  = 2'd0,
        CV_DIGIT = 2'd1,
        CV_HOLD  = 2'd2
    } conv_state_t;

endpackage

// File: hw/rtl/adr_if.sv
interface adr_in_if;
    import adr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel;
    logic [SMP_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface adr_out_if;
    import adr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] ascii_byte;
    logic              last;

    modport source (output valid, output ascii_byte, output last, input ready);
    modport sink   (input valid, input ascii_byte, input last, output ready);
endinterface

// File: hw/rtl/adr_front.sv
module adr_front
    import adr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    adr_in_if.sink     smp_chan,
    input  q_status_t  q_status,
    output logic       push,
    output job_t       push_job
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [SAMPLE_BITS-1:0] held_reg [NUM_CHANNELS];

    logic                   accept;
    logic                   in_range;
    logic [CH_IDX_W-1:0]    idx;
    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] old;
    logic [SAMPLE_BITS-1:0] diff;
    logic [VAL_W-1:0]       smp_ext;
    logic                   changed;

    assign smp_chan.ready = !q_status.full;
    assign accept         = smp_chan.valid && smp_chan.ready;

    assign smp      = smp_chan.sample[SAMPLE_BITS-1:0];
    assign in_range = ({1'b0, smp_chan.channel} < (CHAN_W + 1)'(NUM_CHANNELS));
    assign idx      = smp_chan.channel[CH_IDX_W-1:0];
    assign old      = held_reg[idx];
    assign diff     = (smp > old) ? (smp - old) : (old - smp);
    assign changed  = in_range && (VAL_W'(diff) > cfg.deadband);
    assign smp_ext  = VAL_W'(smp);

    assign push = accept && changed;

    always_comb
    begin
        push_job.panel  = cfg.panel_map[PANEL_W * smp_chan.channel +: PANEL_W];
        push_job.report = (smp_ext < cfg.full_scale) ? (cfg.full_scale - smp_ext) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            held_reg[idx] <= smp;
        end
    end

endmodule

// File: hw/rtl/adr_queue.sv
module adr_queue
    import adr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      pop_job,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/adr_back.sv
module adr_back
    import adr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  job_t      pop_job,
    output logic      pop,
    adr_out_if.source msg_chan
);

    localparam int PROD_W = VAL_W + RECIP_W;

    // Converter: one decimal digit per cycle, least significant first
    conv_state_t        cv_state_reg, cv_state_next;
    logic [VAL_W-1:0]   cur_reg;
    logic [PANEL_W-1:0] panel_reg;
    logic [DIGIT_W-1:0] digit_reg [DIGITS];
    logic [ND_W-1:0]    nd_reg;

    logic [PROD_W-1:0]  prod;
    logic [VAL_W-1:0]   quot;
    logic [VAL_W-1:0]   quot10;
    logic [DIGIT_W-1:0] digit;
    logic               digit_last;
    logic               handoff;

    // Emitter: holds one converted message and walks it byte by byte
    logic               msg_valid_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [PANEL_W-1:0] mpanel_reg;
    logic [DIGIT_W-1:0] mdig_reg [DIGITS];
    logic [ND_W-1:0]    mnd_reg;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;

    logic               load;
    logic               final_pos;
    logic               emit_free;
    logic [POS_W-1:0]   dig_sel;
    logic [BYTE_W-1:0]  cur_byte;

    assign prod       = PROD_W'(cur_reg) * PROD_W'(RECIP_10);
    assign quot       = VAL_W'(prod >> RECIP_SHIFT);
    assign quot10     = (quot << 3) + (quot << 1);
    assign digit      = DIGIT_W'(cur_reg - quot10);
    assign digit_last = (quot == '0) || (nd_reg == ND_W'(DIGITS - 1));

    always_comb
    begin
        cv_state_next = cv_state_reg;
        unique case (cv_state_reg)
            CV_IDLE:
            begin
                if (!q_status.empty)
                begin
                    cv_state_next = CV_DIGIT;
                end
            end
            CV_DIGIT:
            begin
                if (digit_last)
                begin
                    cv_state_next = CV_HOLD;
                end
            end
            CV_HOLD:
            begin
                if (emit_free)
                begin
                    cv_state_next = CV_IDLE;
                end
            end
            default:
            begin
                cv_state_next = CV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop     = 1'b0;
        handoff = 1'b0;
        unique case (cv_state_reg)
            CV_IDLE:  pop     = !q_status.empty;
            CV_DIGIT: ;
            CV_HOLD:  handoff = emit_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_state_reg <= CV_IDLE;
            nd_reg       <= '0;
        end
        else
        begin
            cv_state_reg <= cv_state_next;
            if (pop)
            begin
                nd_reg <= '0;
            end
            else if (cv_state_reg == CV_DIGIT)
            begin
                nd_reg <= nd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg   <= pop_job.report;
            panel_reg <= pop_job.panel;
        end
        else if (cv_state_reg == CV_DIGIT)
        begin
            cur_reg                          <= quot;
            digit_reg[nd_reg[DIG_IDX_W-1:0]] <= digit;
        end
    end

    // Byte order: panel digit, space, digits most significant first, ';'
    assign load      = !out_valid_reg || msg_chan.ready;
    assign final_pos = (pos_reg == POS_W'(mnd_reg) + POS_W'(2));
    assign emit_free = !msg_valid_reg || (load && final_pos);
    assign dig_sel   = POS_W'(mnd_reg) + POS_W'(1) - pos_reg;

    always_comb
    begin
        if (pos_reg == '0)
        begin
            cur_byte = ASC_ZERO + BYTE_W'(mpanel_reg);
        end
        else if (pos_reg == POS_W'(1))
        begin
            cur_byte = ASC_SPACE;
        end
        else if (final_pos)
        begin
            cur_byte = ASC_SEMI;
        end
        else
        begin
            cur_byte = ASC_ZERO + BYTE_W'(mdig_reg[dig_sel[DIG_IDX_W-1:0]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (handoff)
            begin
                msg_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (load && msg_valid_reg)
            begin
                if (final_pos)
                begin
                    msg_valid_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (load)
            begin
                out_valid_reg <= msg_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (handoff)
        begin
            mpanel_reg <= panel_reg;
            mnd_reg    <= nd_reg;
            for (int i = 0; i < DIGITS; i++)
            begin
                mdig_reg[i] <= digit_reg[i];
            end
        end
        if (load)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= final_pos;
        end
    end

    assign msg_chan.valid      = out_valid_reg;
    assign msg_chan.ascii_byte = out_byte_reg;
    assign msg_chan.last       = out_last_reg;

endmodule

// File: hw/rtl/adc_deadband_ascii_reporter_core.sv
// Flow: a sample that moves its channel's held value is queued as a job; the converter
// pops it, forms its decimal digits and hands them to the emitter, whose output register
// gives the first byte once all digits are formed. A sample is accepted every cycle while
// the two-entry job queue has room; each report drains at one byte per cycle while the
// output is ready, and a longer conversion of the next report leaves the output idle.
// Reset: held values clear to zero, registers take their defaults, queue and output empty.
module adc_deadband_ascii_reporter_core
    import adr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    adr_in_if.sink               smp_chan,
    adr_out_if.source            msg_chan
);

    logic [VAL_W-1:0] deadband_reg;
    logic [VAL_W-1:0] full_scale_reg;
    logic [CFG_W-1:0] panel_map_reg;

    cfg_t      cfg;
    q_status_t q_status;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg   <= DEADBAND_RST;
            full_scale_reg <= FULL_SCALE_RST;
            panel_map_reg  <= PANEL_MAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEADBAND:   deadband_reg   <= cfg_wdata[VAL_W-1:0];
                REG_FULL_SCALE: full_scale_reg <= cfg_wdata[VAL_W-1:0];
                REG_PANEL_MAP:  panel_map_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign cfg.deadband   = deadband_reg;
    assign cfg.full_scale = full_scale_reg;
    assign cfg.panel_map  = panel_map_reg;

    adr_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .smp_chan (smp_chan),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    adr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    adr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .msg_chan (msg_chan)
    );

endmodule

// File: hw/rtl/adr_checker.sv
module adr_checker
    import adr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] ascii_byte,
    input logic              last
);

    // Hold a stalled request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ascii_byte) && $stable(last))
        else $error("output request changed while stalled");

    a_last_semi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> ascii_byte == ASC_SEMI)
        else $error("last byte is not the closing semicolon");

    a_semi_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> ascii_byte != ASC_SEMI)
        else $error("semicolon without last flag");

    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ascii_byte >= ASC_ZERO && ascii_byte <= ASC_NINE)
                      || ascii_byte == ASC_SPACE || ascii_byte == ASC_SEMI)
        else $error("byte outside the report character set");

endmodule

bind adc_deadband_ascii_reporter_core adr_checker u_adr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (msg_chan.valid),
    .out_ready  (msg_chan.ready),
    .ascii_byte (msg_chan.ascii_byte),
    .last       (msg_chan.last)
);
